### hdl/assert_macros.svh
// Assertion macros shared by the OSC parser RTL.
// Expects clk and rst_n (sync, active low) in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge out of reset.
`define OSPC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define OSPC_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define OSPC_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/ospc_pkg.sv
// Types, codes and tag helpers for the OSC message stream parser.
// No dependencies; used by the core, ospc_out and the testbench.
package ospc_pkg;

  localparam int CNT_W = 6;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_BIG_S = 8'h53;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_BIG_T = 8'h54;
  localparam logic [7:0] CH_BIG_F = 8'h46;
  localparam logic [7:0] CH_BIG_N = 8'h4E;
  localparam logic [7:0] CH_BIG_I = 8'h49;

  typedef enum logic [2:0] {
    PH_ADDR, PH_TAGS, PH_ARGS, PH_BLOB, PH_IDLE
  } phase_t;

  typedef enum logic [2:0] {
    K_ADDR, K_SCALAR, K_CONTENT, K_END, K_ACCEPT, K_ERROR
  } kind_t;

  typedef enum logic [2:0] {
    E_BAD_ADDR, E_BAD_TAGSTR, E_UNTERM, E_SHORT, E_NEG_BLOB, E_OVERRUN,
    E_BAD_TAG, E_MANY_TAGS
  } err_t;

  typedef enum logic [1:0] {
    SQ_IN, SQ_BEND, SQ_CHAIN, SQ_TAIL
  } seq_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tag;
    logic [5:0]  idx;
    logic [63:0] val;
    logic [7:0]  cb;
    err_t        err;
  } res_t;

  // push: new result; fin: it ends the byte's run; flush: mark held one as end
  typedef struct packed {
    logic push;
    logic fin;
    logic flush;
  } emit_ctl_t;

  function automatic logic [3:0] scalar_len(input logic [7:0] t);
    logic [3:0] n;
    n = 4'd0;
    if (t == CH_I || t == CH_F || t == CH_C || t == CH_R || t == CH_M || t == CH_B) n = 4'd4;
    if (t == CH_H || t == CH_D || t == CH_T) n = 4'd8;
    return n;
  endfunction

  function automatic logic is_str(input logic [7:0] t);
    return (t == CH_S) || (t == CH_BIG_S);
  endfunction

  function automatic logic is_dataless(input logic [7:0] t);
    return (t == CH_BIG_T) || (t == CH_BIG_I) || (t == CH_BIG_F) || (t == CH_BIG_N);
  endfunction

endpackage

### hdl/ospc_ifs.sv
// Valid/ready channel interfaces for the OSC parser byte input and tokens.
// Depends on nothing.
interface osc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface osc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [7:0]  type_tag;
  logic [5:0]  arg_index;
  logic [63:0] arg_value;
  logic [7:0]  content_byte;
  logic [2:0]  error_code;
  logic        last_of_run;
  modport source (output valid, output token_kind, output type_tag, output arg_index,
                  output arg_value, output content_byte, output error_code,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input type_tag, input arg_index,
                input arg_value, input content_byte, input error_code,
                input last_of_run, output ready);
endinterface

### hdl/osc_message_stream_parser_core.sv
// OSC 1.0 message stream parser, top level: byte sequencer around the tag RAM.
// Depends on ospc_pkg, ospc_ifs, ospc_ram, ospc_out and assert_macros.svh.
//
// Use: in_ch carries one packet byte per beat (data_byte, last_byte marks the
// final byte). out_ch carries tokens: address bytes, scalars, string/blob
// bytes, content ends, accepted and error; last_of_run flags the final token
// a byte caused. Both are valid/ready; a beat moves when both are high.
// A token goes through the hold slot and the output register to out_ch.
// Throughput: one byte per cycle for address, tag and argument bytes unless
// out_ch stalls. in_ch.ready is low during the tag chain walk after an
// argument or the tag string ends (a tag RAM read per tag visited), a blob's
// end token and a truncation's error token. The tag RAM has one read port,
// so the dataless-tag chain walks it a tag per cycle unless out_ch stalls.
// Reset clears the sequencer and packet state and empties the output; the
// tag RAM needs no clearing since only tags written in the current packet
// are read. When out_ch stalls, the hold slot and output register fill and
// then in_ch.ready drops until the receiver takes beats.
module osc_message_stream_parser_core
  import ospc_pkg::*;
#(
  parameter int MAX_TAGS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  osc_in_if.sink   in_ch,
  osc_out_if.source out_ch
);
  `include "assert_macros.svh"

  localparam int AW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TAGS);

  // Packet state
  phase_t           phase_r, phase_nxt;
  seq_t             seq_r, seq_nxt;
  logic [1:0]       off_r, off_nxt;
  logic             start_r, start_nxt;
  logic [CNT_W-1:0] tag_cnt_r, tag_cnt_nxt;
  logic [CNT_W-1:0] argp_r, argp_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic [3:0]       sleft_r, sleft_nxt;
  logic [30:0]      bleft_r, bleft_nxt;
  logic [7:0]       cur_tag_r, cur_tag_nxt;
  logic             last_r, last_nxt;

  // Step control
  emit_ctl_t  ctl;
  res_t       res;
  logic       push_ok, in_ready, acc_in, lastq;
  logic       go_chain, go_bend, go_tail, endb, tail_done, clr;
  logic       we;
  logic [AW-1:0] rd_addr;
  logic [7:0] rd_tag, b;
  logic [63:0] accv, base;
  logic [3:0]  sl, len;
  logic [30:0] bl;

  function automatic res_t mk(input kind_t k, input logic [7:0] t, input logic [5:0] i,
                              input logic [63:0] v, input logic [7:0] c, input err_t e);
    res_t r;
    r.kind = k; r.tag = t; r.idx = i; r.val = v; r.cb = c; r.err = e;
    return r;
  endfunction

  assign b        = in_ch.data_byte;
  assign in_ready = (seq_r == SQ_IN) && push_ok;
  assign acc_in   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;
  assign lastq    = (seq_r == SQ_IN) ? in_ch.last_byte : last_r;
  assign accv     = {acc_r[55:0], b};
  assign len      = scalar_len(cur_tag_r);

  // Read port follows the next arg pointer so the chain sees its tag next cycle
  assign rd_addr = (argp_nxt < MAX_CNT) ? argp_nxt[AW-1:0] : '0;

  ospc_ram #(.W(8), .D(MAX_TAGS)) u_tags (
    .clk   (clk),
    .we    (we),
    .waddr (tag_cnt_r[AW-1:0]),
    .wdata (b),
    .raddr (rd_addr),
    .rdata (rd_tag)
  );

  ospc_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .res     (res),
    .push_ok (push_ok),
    .out_ch  (out_ch)
  );

  // Datapath: one byte step, one blob end, one chain step or the tail error
  always_comb begin
    phase_nxt = phase_r;  off_nxt = off_r;     start_nxt = start_r;
    tag_cnt_nxt = tag_cnt_r; argp_nxt = argp_r; acc_nxt = acc_r;
    sleft_nxt = sleft_r;  bleft_nxt = bleft_r; cur_tag_nxt = cur_tag_r;
    last_nxt = last_r;
    ctl = '0;
    res = mk(K_ADDR, 8'd0, 6'd0, 64'd0, 8'd0, E_BAD_ADDR);
    we = 1'b0; go_chain = 1'b0; go_bend = 1'b0; endb = 1'b0;
    tail_done = 1'b0; clr = 1'b0;
    base = 64'd0;
    sl = 4'd0;
    bl = 31'd0;
    unique case (seq_r)
      SQ_IN: begin
        if (acc_in) begin
          last_nxt = in_ch.last_byte;
          off_nxt  = off_r + 2'd1;
          unique case (phase_r)
            PH_ADDR: begin
              if (start_r) begin
                ctl.push = 1'b1;
                if (b != CH_SLASH) begin
                  res = mk(K_ERROR, 8'd0, argp_r, 64'd0, 8'd0, E_BAD_ADDR);
                  phase_nxt = PH_IDLE;
                end else begin
                  res = mk(K_ADDR, 8'd0, 6'd0, 64'd0, b, E_BAD_ADDR);
                  acc_nxt = 64'd1;
                  start_nxt = 1'b0;
                end
              end else if (b == 8'd0) begin
                ctl.push = 1'b1;
                res = mk(K_END, 8'd0, 6'd0, acc_r, 8'd0, E_BAD_ADDR);
                phase_nxt = PH_TAGS;
                start_nxt = 1'b1;
              end else begin
                ctl.push = 1'b1;
                res = mk(K_ADDR, 8'd0, 6'd0, 64'd0, b, E_BAD_ADDR);
                acc_nxt = acc_r + 64'd1;
              end
            end
            PH_TAGS: begin
              if (start_r) begin
                if (off_r == 2'd0) begin
                  if (b != CH_COMMA) begin
                    ctl.push = 1'b1;
                    res = mk(K_ERROR, 8'd0, argp_r, 64'd0, 8'd0, E_BAD_TAGSTR);
                    phase_nxt = PH_IDLE;
                  end else begin
                    start_nxt = 1'b0;
                  end
                end
              end else if (b == 8'd0) begin
                argp_nxt = '0;
                go_chain = 1'b1;
              end else if (tag_cnt_r >= MAX_CNT) begin
                ctl.push = 1'b1;
                res = mk(K_ERROR, 8'd0, argp_r, 64'd0, 8'd0, E_MANY_TAGS);
                phase_nxt = PH_IDLE;
              end else begin
                we = 1'b1;
                tag_cnt_nxt = tag_cnt_r + 1'b1;
              end
            end
            PH_ARGS: begin
              if (start_r && off_r != 2'd0) begin
                // padding before the next argument
              end else if (start_r && !is_str(cur_tag_r) && len == 4'd0) begin
                ctl.push = 1'b1;
                res = mk(K_ERROR, cur_tag_r, argp_r, 64'd0, 8'd0, E_BAD_TAG);
                phase_nxt = PH_IDLE;
              end else if (start_r && !is_str(cur_tag_r)) begin
                start_nxt = 1'b0;
                acc_nxt = {56'd0, b};
                sleft_nxt = len - 4'd1;
              end else if (is_str(cur_tag_r)) begin
                base = start_r ? 64'd0 : acc_r;
                start_nxt = 1'b0;
                ctl.push = 1'b1;
                if (b == 8'd0) begin
                  res = mk(K_END, cur_tag_r, argp_r, base, 8'd0, E_BAD_ADDR);
                  argp_nxt = argp_r + 1'b1;
                  go_chain = 1'b1;
                end else begin
                  res = mk(K_CONTENT, cur_tag_r, argp_r, 64'd0, b, E_BAD_ADDR);
                  acc_nxt = base + 64'd1;
                end
              end else begin
                // scalar or blob size byte
                sl = (sleft_r != 4'd0) ? sleft_r - 4'd1 : 4'd0;
                acc_nxt = accv;
                sleft_nxt = sl;
                if (sl == 4'd0) begin
                  ctl.push = 1'b1;
                  if (cur_tag_r == CH_B) begin
                    bl = accv[30:0];
                    if (accv[31]) begin
                      res = mk(K_ERROR, cur_tag_r, argp_r, 64'd0, 8'd0, E_NEG_BLOB);
                      phase_nxt = PH_IDLE;
                    end else begin
                      acc_nxt = {33'd0, bl};
                      bleft_nxt = bl;
                      if (bl == 31'd0) begin
                        res = mk(K_END, cur_tag_r, argp_r, 64'd0, 8'd0, E_BAD_ADDR);
                        argp_nxt = argp_r + 1'b1;
                        go_chain = 1'b1;
                      end else begin
                        ctl.push = 1'b0;
                        phase_nxt = PH_BLOB;
                      end
                    end
                  end else begin
                    res = mk(K_SCALAR, cur_tag_r, argp_r, accv, 8'd0, E_BAD_ADDR);
                    argp_nxt = argp_r + 1'b1;
                    go_chain = 1'b1;
                  end
                end
              end
            end
            PH_BLOB: begin
              ctl.push = 1'b1;
              res = mk(K_CONTENT, cur_tag_r, argp_r, 64'd0, b, E_BAD_ADDR);
              bl = (bleft_r != 31'd0) ? bleft_r - 31'd1 : 31'd0;
              bleft_nxt = bl;
              go_bend = (bl == 31'd0);
            end
            default: begin
              // idle: bytes ignored until the final one
            end
          endcase
          endb = !go_chain && !go_bend;
        end
      end
      SQ_BEND: begin
        if (push_ok) begin
          ctl.push = 1'b1;
          res = mk(K_END, cur_tag_r, argp_r, acc_r, 8'd0, E_BAD_ADDR);
          argp_nxt = argp_r + 1'b1;
          go_chain = 1'b1;
        end
      end
      SQ_CHAIN: begin
        if (argp_r >= tag_cnt_r) begin
          if (push_ok) begin
            ctl.push = 1'b1;
            res = mk(K_ACCEPT, 8'd0, argp_r, 64'd0, 8'd0, E_BAD_ADDR);
            phase_nxt = PH_IDLE;
            endb = 1'b1;
          end
        end else if (is_dataless(rd_tag)) begin
          if (push_ok) begin
            ctl.push = 1'b1;
            res = mk(K_SCALAR, rd_tag, argp_r,
                     {63'd0, (rd_tag == CH_BIG_T) || (rd_tag == CH_BIG_I)}, 8'd0, E_BAD_ADDR);
            argp_nxt = argp_r + 1'b1;
          end
        end else if (is_str(rd_tag) || scalar_len(rd_tag) != 4'd0) begin
          phase_nxt = PH_ARGS;
          start_nxt = 1'b1;
          cur_tag_nxt = rd_tag;
          endb = 1'b1;
        end else if (push_ok) begin
          ctl.push = 1'b1;
          res = mk(K_ERROR, rd_tag, argp_r, 64'd0, 8'd0, E_BAD_TAG);
          phase_nxt = PH_IDLE;
          endb = 1'b1;
        end
      end
      SQ_TAIL: begin
        if (push_ok) begin
          ctl.push = 1'b1;
          ctl.fin = 1'b1;
          if (phase_r == PH_BLOB) begin
            res = mk(K_ERROR, cur_tag_r, argp_r, 64'd0, 8'd0, E_OVERRUN);
          end else if (phase_r == PH_ARGS) begin
            res = mk(K_ERROR, cur_tag_r, argp_r, 64'd0, 8'd0,
                     is_str(cur_tag_r) ? E_UNTERM : E_SHORT);
          end else begin
            res = mk(K_ERROR, 8'd0, argp_r, 64'd0, 8'd0, E_UNTERM);
          end
          tail_done = 1'b1;
          clr = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // End of a byte's run: a truncated packet still owes an error token
    go_tail = endb && lastq && (phase_nxt != PH_IDLE);
    if (endb && !go_tail) begin
      ctl.fin = ctl.push;
      ctl.flush = !ctl.push;
      clr = lastq;
    end

    if (clr) begin
      phase_nxt = PH_ADDR;  off_nxt = 2'd0;  start_nxt = 1'b1;
      tag_cnt_nxt = '0;     argp_nxt = '0;   acc_nxt = 64'd0;
      sleft_nxt = 4'd0;     bleft_nxt = 31'd0;
    end
  end

  // Sequencer next state
  always_comb begin
    priority if (go_bend) begin
      seq_nxt = SQ_BEND;
    end else if (go_chain) begin
      seq_nxt = SQ_CHAIN;
    end else if (go_tail) begin
      seq_nxt = SQ_TAIL;
    end else if (endb || tail_done) begin
      seq_nxt = SQ_IN;
    end else begin
      seq_nxt = seq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r     <= SQ_IN;
      phase_r   <= PH_ADDR;
      off_r     <= 2'd0;
      start_r   <= 1'b1;
      tag_cnt_r <= '0;
      argp_r    <= '0;
      acc_r     <= 64'd0;
      sleft_r   <= 4'd0;
      bleft_r   <= 31'd0;
      last_r    <= 1'b0;
    end else begin
      seq_r     <= seq_nxt;
      phase_r   <= phase_nxt;
      off_r     <= off_nxt;
      start_r   <= start_nxt;
      tag_cnt_r <= tag_cnt_nxt;
      argp_r    <= argp_nxt;
      acc_r     <= acc_nxt;
      sleft_r   <= sleft_nxt;
      bleft_r   <= bleft_nxt;
      last_r    <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_tag_r <= cur_tag_nxt;
  end

  `OSPC_CHECK(a_cnt_bound, tag_cnt_r <= MAX_CNT, "tag count above limit")
  `OSPC_IMPLY(a_arg_live, (seq_r == SQ_IN) && ((phase_r == PH_ARGS) || (phase_r == PH_BLOB)), argp_r < tag_cnt_r, "arg pointer past stored tags")
  `OSPC_NEXT(a_last_clears, acc_in && in_ch.last_byte && (phase_r == PH_IDLE), (seq_r == SQ_IN) && (phase_r == PH_ADDR) && (tag_cnt_r == '0), "final byte did not restart packet")
endmodule

### hdl/ospc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ospc_ram #(
  parameter int W = 8,
  parameter int D = 32,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/ospc_out.sv
// Token output staging: a hold slot that learns the end-of-run mark,
// then the output register. Depends on ospc_pkg and osc_out_if.
module ospc_out
  import ospc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  emit_ctl_t ctl,
  input  res_t      res,
  output logic      push_ok,
  osc_out_if.source out_ch
);
  logic pend_v_r, pend_fin_r, out_v_r, out_last_r;
  res_t pend_r, out_res_r;
  logic out_free, move;

  assign out_free = !out_v_r || out_ch.ready;
  assign push_ok  = !pend_v_r || out_free;
  assign move     = pend_v_r && out_free && (ctl.push || pend_fin_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r   <= 1'b0;
      pend_fin_r <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (out_free) begin
        out_v_r <= move;
      end
      if (ctl.push) begin
        pend_v_r   <= 1'b1;
        pend_fin_r <= ctl.fin;
      end else if (move) begin
        pend_v_r <= 1'b0;
      end else if (ctl.flush && pend_v_r) begin
        pend_fin_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      pend_r <= res;
    end
    if (move) begin
      out_res_r  <= pend_r;
      out_last_r <= pend_fin_r;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.token_kind   = out_res_r.kind;
  assign out_ch.type_tag     = out_res_r.tag;
  assign out_ch.arg_index    = out_res_r.idx;
  assign out_ch.arg_value    = out_res_r.val;
  assign out_ch.content_byte = out_res_r.cb;
  assign out_ch.error_code   = out_res_r.err;
  assign out_ch.last_of_run  = out_last_r;
endmodule

### dv/tb_top.sv
// Testbench for osc_message_stream_parser_core: directed and random OSC packets.
// Depends on ospc_pkg, ospc_ifs and the core (hdl); a self-contained token predictor checks out_ch.
module tb_top;
  import ospc_pkg::*;

  localparam int MAX_TAGS = 32;
  localparam int RAND_BYTES = 350;

  // One expected or observed token
  typedef struct {
    kind_t       kind;
    logic [7:0]  tag;
    logic [5:0]  idx;
    logic [63:0] val;
    logic [7:0]  cb;
    err_t        err;
    logic        fin;
  } token_t;

  logic clk;
  logic rst_n;

  osc_in_if  in_ch ();
  osc_out_if out_ch ();

  osc_message_stream_parser_core #(.MAX_TAGS(MAX_TAGS)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // Token predictor and scoreboard
  class osc_token_board;
    token_t     pending_q[$];
    token_t     run_q[$];
    int         errors;
    int         tokens_seen;
    int         n_accept;
    int         n_error;
    phase_t     phase;
    logic [1:0] boff;
    logic       at_start;
    logic [7:0] tags [MAX_TAGS];
    int unsigned ntags;
    int unsigned argp;
    logic [63:0] acc;
    int unsigned sleft;
    logic [30:0] bleft;

    function void new_packet();
      phase = PH_ADDR; boff = 0; at_start = 1; ntags = 0; argp = 0;
      acc = 0; sleft = 0; bleft = 0;
    endfunction

    function void add_tok(kind_t k, logic [7:0] tg, int unsigned ix, logic [63:0] v,
                          logic [7:0] c, err_t e);
      token_t t;
      if (run_q.size() >= MAX_TAGS + 2) return;
      t.kind = k; t.tag = tg; t.idx = ix[5:0]; t.val = v; t.cb = c; t.err = e; t.fin = 0;
      run_q.insert(run_q.size(), t);
    endfunction

    function logic [7:0] tag_at(int unsigned p);
      return (p < ntags) ? tags[p] : 8'h00;
    endfunction

    function int unsigned width_of(logic [7:0] t);
      case (t)
        CH_I, CH_F, CH_C, CH_R, CH_M, CH_B: return 4;
        CH_H, CH_D, CH_T:                   return 8;
        default:                            return 0;
      endcase
    endfunction

    function bit text_tag(logic [7:0] t);
      return t == CH_S || t == CH_BIG_S;
    endfunction

    function void abort(logic [7:0] tg, err_t e);
      phase = PH_IDLE;
      add_tok(K_ERROR, tg, argp, 0, 0, e);
    endfunction

    // Walk dataless tags until a data tag, the end of the list or a bad tag
    function void walk_tags();
      logic [7:0] t;
      forever begin
        if (argp >= ntags) begin
          phase = PH_IDLE;
          add_tok(K_ACCEPT, 0, argp, 0, 0, E_BAD_ADDR);
          return;
        end
        t = tag_at(argp);
        if (t == CH_BIG_T || t == CH_BIG_I || t == CH_BIG_F || t == CH_BIG_N) begin
          add_tok(K_SCALAR, t, argp, (t == CH_BIG_T || t == CH_BIG_I) ? 64'd1 : 64'd0,
                  0, E_BAD_ADDR);
          argp++;
        end else if (text_tag(t) || width_of(t) != 0) begin
          phase = PH_ARGS;
          at_start = 1;
          return;
        end else begin
          abort(t, E_BAD_TAG);
          return;
        end
      end
    endfunction

    function void next_arg();
      argp++;
      walk_tags();
    endfunction

    function void note_byte(logic [7:0] b, logic lst);
      logic [1:0] off;
      logic [7:0] t;
      bit         done;
      err_t       code;
      off = boff;
      boff = boff + 2'd1;
      run_q.delete();
      done = 0;
      case (phase)
        PH_ADDR: begin
          if (at_start) begin
            if (b != CH_SLASH) abort(0, E_BAD_ADDR);
            else begin
              add_tok(K_ADDR, 0, 0, 0, b, E_BAD_ADDR);
              acc = 1;
              at_start = 0;
            end
          end else if (b == 0) begin
            add_tok(K_END, 0, 0, acc, 0, E_BAD_ADDR);
            phase = PH_TAGS;
            at_start = 1;
          end else begin
            add_tok(K_ADDR, 0, 0, 0, b, E_BAD_ADDR);
            acc++;
          end
        end
        PH_TAGS: begin
          if (at_start) begin
            if (off == 0) begin
              if (b != CH_COMMA) abort(0, E_BAD_TAGSTR);
              else at_start = 0;
            end
          end else if (b == 0) begin
            argp = 0;
            walk_tags();
          end else if (ntags >= MAX_TAGS) begin
            abort(0, E_MANY_TAGS);
          end else begin
            tags[ntags] = b;
            ntags++;
          end
        end
        PH_ARGS: begin
          t = tag_at(argp);
          if (at_start) begin
            if (off != 0) done = 1;
            else if (text_tag(t)) begin
              at_start = 0;
              acc = 0;
            end else if (width_of(t) != 0) begin
              at_start = 0;
              acc = {56'd0, b};
              sleft = width_of(t) - 1;
              done = 1;
            end else begin
              abort(t, E_BAD_TAG);
              done = 1;
            end
          end
          if (!done) begin
            if (text_tag(t)) begin
              if (b == 0) begin
                add_tok(K_END, t, argp, acc, 0, E_BAD_ADDR);
                next_arg();
              end else begin
                add_tok(K_CONTENT, t, argp, 0, b, E_BAD_ADDR);
                acc++;
              end
            end else begin
              acc = {acc[55:0], b};
              if (sleft > 0) sleft--;
              if (sleft == 0) begin
                if (t == CH_B) begin
                  if (acc[31]) abort(t, E_NEG_BLOB);
                  else begin
                    acc = acc & 64'h7FFF_FFFF;
                    bleft = acc[30:0];
                    if (bleft == 0) begin
                      add_tok(K_END, t, argp, 0, 0, E_BAD_ADDR);
                      next_arg();
                    end else phase = PH_BLOB;
                  end
                end else begin
                  add_tok(K_SCALAR, t, argp, acc, 0, E_BAD_ADDR);
                  next_arg();
                end
              end
            end
          end
        end
        PH_BLOB: begin
          t = tag_at(argp);
          add_tok(K_CONTENT, t, argp, 0, b, E_BAD_ADDR);
          if (bleft > 0) bleft--;
          if (bleft == 0) begin
            add_tok(K_END, t, argp, acc, 0, E_BAD_ADDR);
            next_arg();
          end
        end
        default: ;
      endcase
      // final byte: report truncation, then back to the start state
      if (lst) begin
        if (phase != PH_IDLE) begin
          code = E_UNTERM;
          t = 0;
          if (phase == PH_BLOB) begin
            t = tag_at(argp);
            code = E_OVERRUN;
          end else if (phase == PH_ARGS) begin
            t = tag_at(argp);
            code = text_tag(t) ? E_UNTERM : E_SHORT;
          end
          abort(t, code);
        end
        new_packet();
      end
      if (run_q.size() > 0) run_q[run_q.size()-1].fin = 1;
      foreach (run_q[i]) pending_q.insert(pending_q.size(), run_q[i]);
    endfunction

    function void check_token(token_t got);
      token_t exp;
      tokens_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected token kind=%0d", got.kind);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (exp.kind == K_ACCEPT) n_accept++;
      if (exp.kind == K_ERROR) n_error++;
      if (got.kind !== exp.kind) begin
        $error("token_kind exp %0d got %0d", exp.kind, got.kind); errors++;
      end
      if (got.tag !== exp.tag) begin
        $error("type_tag exp %0h got %0h", exp.tag, got.tag); errors++;
      end
      if (got.idx !== exp.idx) begin
        $error("arg_index exp %0d got %0d", exp.idx, got.idx); errors++;
      end
      if (got.val !== exp.val) begin
        $error("arg_value exp %0h got %0h", exp.val, got.val); errors++;
      end
      if (got.cb !== exp.cb) begin
        $error("content_byte exp %0h got %0h", exp.cb, got.cb); errors++;
      end
      if (got.err !== exp.err) begin
        $error("error_code exp %0d got %0d", exp.err, got.err); errors++;
      end
      if (got.fin !== exp.fin) begin
        $error("last_of_run exp %0b got %0b", exp.fin, got.fin); errors++;
      end
    endfunction
  endclass

  osc_token_board board;
  logic [7:0] pkt [$];
  int  bytes_sent;
  int  packets;
  bit  no_gaps;
  bit  sink_busy;

  initial begin
    board = new();
    board.new_packet();
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, toggled off for some stretches
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= pick_gap();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    token_t got;
    if (rst_n && in_ch.valid && in_ch.ready) board.note_byte(in_ch.data_byte, in_ch.last_byte);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind = kind_t'(out_ch.token_kind);
      got.tag  = out_ch.type_tag;
      got.idx  = out_ch.arg_index;
      got.val  = out_ch.arg_value;
      got.cb   = out_ch.content_byte;
      got.err  = err_t'(out_ch.error_code);
      got.fin  = out_ch.last_of_run;
      board.check_token(got);
    end
  end

  // one beat; valid stays high across back-to-back beats
  task automatic send_beat(logic [7:0] b, logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // append one byte to the packet under construction
  function automatic void add_byte(logic [7:0] v);
    pkt.insert(pkt.size(), v);
  endfunction

  task automatic send_packet();
    foreach (pkt[i]) send_beat(pkt[i], i == pkt.size() - 1);
    pkt.delete();
    packets++;
  endtask

  task automatic pad4();
    while (pkt.size() % 4 != 0) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    add_byte(8'h00);
    pad4();
  endtask

  task automatic add_rand_text(int n);
    repeat (n) add_byte(8'($urandom_range(1, 255)));
    add_byte(8'h00);
    pad4();
  endtask

  task automatic add_word(logic [31:0] w);
    for (int i = 3; i >= 0; i--) add_byte(w[8*i +: 8]);
  endtask

  task automatic add_head(string tl);
    add_text("/a");
    add_text({",", tl});
  endtask

  // random argument payload for one tag
  task automatic add_arg(logic [7:0] t);
    int n;
    case (t)
      CH_S, CH_BIG_S: add_rand_text($urandom_range(0, 6));
      CH_B: begin
        n = $urandom_range(0, 6);
        add_word(n);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
        pad4();
      end
      CH_H, CH_D, CH_T: repeat (8) add_byte(8'($urandom_range(0, 255)));
      CH_I, CH_F, CH_C, CH_R, CH_M: repeat (4) add_byte(8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  logic [7:0] tag_pool [] = '{CH_I, CH_H, CH_F, CH_D, CH_S, CH_BIG_S, CH_B, CH_T, CH_C,
                              CH_M, CH_R, CH_BIG_T, CH_BIG_F, CH_BIG_N, CH_BIG_I};

  task automatic build_random();
    logic [7:0] tl [$];
    int nt;
    int cut;
    add_byte(CH_SLASH);
    add_rand_text($urandom_range(0, 6));
    nt = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 33) : $urandom_range(0, 6);
    repeat (nt) begin
      if ($urandom_range(0, 29) == 0) tl.insert(tl.size(), 8'h7A);
      else tl.insert(tl.size(), tag_pool[$urandom_range(0, tag_pool.size() - 1)]);
    end
    add_byte(CH_COMMA);
    foreach (tl[i]) add_byte(tl[i]);
    add_byte(8'h00);
    pad4();
    foreach (tl[i]) add_arg(tl[i]);
    // broken packets: truncate, corrupt a byte, or leave trailing bytes
    case ($urandom_range(0, 19))
      0, 1: begin
        cut = $urandom_range(1, pkt.size());
        while (pkt.size() > cut) void'(pkt.pop_back());
      end
      2: pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom_range(0, 255));
      3: repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  initial begin
    int wait_cycles;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    bytes_sent = 0;
    packets = 0;
    no_gaps = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // address must start with a slash; a NUL there is also rejected
    add_byte(8'h78); add_byte(8'hFF); send_packet();
    add_byte(8'h00); send_packet();
    // tag string missing its comma
    add_text("/ab"); add_text("if"); send_packet();
    // every scalar width, all-ones and all-zeros values
    add_head("ihfdcmrt");
    add_word(32'hFFFF_FFFF); add_word(0); add_word(0); add_word(32'hFFFF_FFFF);
    add_word(32'hFFFF_FFFF); add_word(32'h8000_0001); add_word(32'h7F00_00FF);
    add_word(32'h0123_4567); add_word(32'h89AB_CDEF); add_word(32'h1);
    add_word(32'h2); add_word(32'h3);
    send_packet();
    // strings with zero and full-range content, then blobs of zero and odd size
    add_head("sSbb");
    add_byte(8'h00); pad4(); add_text("\xFF\x01xyz");
    add_word(0); add_word(3); add_byte(8'hAA); add_byte(8'h55); add_byte(8'h00);
    send_packet();
    // negative blob size
    add_head("b"); add_word(32'h8000_0000); send_packet();
    // dataless tags only, one chain of the full store depth
    add_head("TFNITTTTTTTTTTTTTTTTTTTTTTTTTTTT"); send_packet();
    // one tag too many
    add_head("TTTTTTTTTTTTTTTTTTTTTTTTTTTTTTTTT"); send_packet();
    // unsupported tag after a scalar
    add_head("iz"); add_word(7); send_packet();
    // truncation: inside the address, tag string, string, scalar, blob size, blob data
    add_byte(CH_SLASH); add_byte(8'h61); send_packet();
    add_text("/a"); add_byte(CH_COMMA); send_packet();
    add_head("s"); add_byte(8'h61); send_packet();
    add_head("h"); add_word(1); send_packet();
    add_head("b"); add_byte(8'h00); send_packet();
    add_head("b"); add_word(8); add_byte(8'h11); send_packet();
    // no padding after the last item, and bytes after acceptance
    add_head("s"); add_byte(8'h41); add_byte(8'h00); send_packet();
    add_head("i"); add_word(5); add_word(6); send_packet();
    add_text("/"); add_byte(CH_COMMA); add_byte(8'h00); send_packet();

    // random packets; some stretches with no idling
    while (bytes_sent < RAND_BYTES) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      build_random();
      send_packet();
    end
    in_ch.valid <= 1'b0;
    no_gaps = 0;

    wait_cycles = 0;
    while (board.pending_q.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (50) @(posedge clk);

    $display("covered %0d packets, %0d bytes, %0d tokens (%0d accepted, %0d errors)",
             packets, bytes_sent, board.tokens_seen, board.n_accept, board.n_error);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("[osc_message_stream_parser_core] OK");
    end else begin
      $display("[osc_message_stream_parser_core] ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[osc_message_stream_parser_core] ERROR");
    $finish;
  end

endmodule
